@@ hdl/cpio_pkg.sv @@
// Shared types, constants and helper functions for the cpio newc archive walker.
// No dependencies.
`default_nettype none

package cpio_pkg;

  localparam int unsigned ENTRY_INDEX_BITS = 16;

  localparam logic [31:0] HDR_LEN     = 32'd110;
  localparam logic [31:0] FSIZE_AT    = 32'd54;
  localparam logic [31:0] NSIZE_AT    = 32'd94;
  localparam logic [31:0] FIELD_LEN   = 32'd8;
  localparam logic [31:0] TRAILER_LEN = 32'd10;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_NPAD   = 3'd2,
    PH_DATA   = 3'd3,
    PH_DPAD   = 3'd4,
    PH_END    = 3'd5
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] b);
    hex_digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.value = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.value = 4'(b - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cpio_newc_archive_walker_top.sv @@
// Top level of the cpio newc archive walker: input register, byte classifier, output register.
// Depends on cpio_pkg.
//
// The walker takes one archive byte per transaction and returns one tagged byte per
// transaction, one per clock when neither side stalls. A byte passes through the input
// register and then the output register; the classification and the header/size state
// update sit between them, and the position counter and hex accumulator update once per
// byte, so the sustained rate is one byte per cycle. After reset the walker expects the
// first byte of a newc header; there is no clearing pass.
`default_nettype none

module cpio_newc_archive_walker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  archive_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [2:0]       region,
  output logic [15:0]      entry_index,
  output logic [31:0]      region_offset,
  output logic             region_last,
  output logic             bad_hex,
  output logic             archive_end
);

  localparam int unsigned EW = cpio_pkg::ENTRY_INDEX_BITS;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_adv;

  cpio_pkg::phase_t phase, phase_next;
  logic [31:0] position, position_next;
  logic [31:0] hex_acc, hex_acc_next;
  logic        field_done, field_done_next;
  logic [31:0] name_length, name_length_next;
  logic [31:0] data_length, data_length_next;
  logic [EW-1:0] entry_count, entry_count_next;
  logic        trailer_match, trailer_match_next;
  logic        bad_flag, bad_flag_next;

  cpio_pkg::phase_t out_region;
  logic [EW-1:0] out_entry;

  logic        last;
  logic        ended;
  logic [1:0]  npad_len;
  logic [1:0]  dpad_len;
  logic [31:0] cur_len;
  logic        in_field;
  logic        field_start;
  logic [31:0] acc_in;
  logic        done_in;
  logic [2:0]  start_ph;
  cpio_pkg::hex_digit_t dig;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  assign npad_len = 2'd2 - name_length[1:0];
  assign dpad_len = 2'd0 - data_length[1:0];
  assign dig      = cpio_pkg::hex_digit(s1_byte);

  always_comb begin
    unique case (phase)
      cpio_pkg::PH_HEADER: cur_len = cpio_pkg::HDR_LEN;
      cpio_pkg::PH_NAME:   cur_len = name_length;
      cpio_pkg::PH_NPAD:   cur_len = {30'd0, npad_len};
      cpio_pkg::PH_DATA:   cur_len = data_length;
      cpio_pkg::PH_DPAD:   cur_len = {30'd0, dpad_len};
      default:             cur_len = 32'd0;
    endcase
  end

  assign last = (phase != cpio_pkg::PH_END) && (position == cur_len - 32'd1);

  assign field_start = (position == cpio_pkg::FSIZE_AT) || (position == cpio_pkg::NSIZE_AT);
  assign in_field =
    ((position >= cpio_pkg::FSIZE_AT) &&
     (position < cpio_pkg::FSIZE_AT + cpio_pkg::FIELD_LEN)) ||
    ((position >= cpio_pkg::NSIZE_AT) &&
     (position < cpio_pkg::NSIZE_AT + cpio_pkg::FIELD_LEN));
  assign acc_in  = field_start ? 32'd0 : hex_acc;
  assign done_in = field_start ? 1'b0 : field_done;

  always_comb begin
    phase_next         = phase;
    position_next      = position + 32'd1;
    hex_acc_next       = hex_acc;
    field_done_next    = field_done;
    name_length_next   = name_length;
    data_length_next   = data_length;
    entry_count_next   = entry_count;
    trailer_match_next = trailer_match;
    bad_flag_next      = bad_flag;
    start_ph           = 3'(phase) + 3'd1;

    unique case (phase)
      cpio_pkg::PH_HEADER: begin
        if (position == 32'd0) begin
          bad_flag_next      = 1'b0;
          trailer_match_next = 1'b1;
        end
        if (field_start) begin
          hex_acc_next    = 32'd0;
          field_done_next = 1'b0;
        end
        if (in_field && !done_in) begin
          if (s1_byte == 8'd0) begin
            field_done_next = 1'b1;
          end else if (dig.ok) begin
            hex_acc_next = {acc_in[27:0], 4'd0} + {28'd0, dig.value};
          end else begin
            hex_acc_next    = 32'hFFFF_FFFF;
            field_done_next = 1'b1;
            bad_flag_next   = 1'b1;
          end
        end
        if (position == cpio_pkg::FSIZE_AT + cpio_pkg::FIELD_LEN - 32'd1) begin
          data_length_next = hex_acc_next;
        end
        if (position == cpio_pkg::NSIZE_AT + cpio_pkg::FIELD_LEN - 32'd1) begin
          name_length_next = hex_acc_next;
        end
        if (last && name_length < cpio_pkg::TRAILER_LEN) begin
          trailer_match_next = 1'b0;
        end
      end
      cpio_pkg::PH_NAME: begin
        if (position < cpio_pkg::TRAILER_LEN) begin
          if (s1_byte != cpio_pkg::trailer_char(position[3:0])) begin
            trailer_match_next = 1'b0;
          end
        end else if (position == cpio_pkg::TRAILER_LEN) begin
          if (s1_byte != 8'd0) begin
            trailer_match_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    if (last) begin
      position_next = 32'd0;
      priority if (start_ph <= 3'd1 && name_length != 32'd0) begin
        phase_next = cpio_pkg::PH_NAME;
      end else if (start_ph <= 3'd2 && npad_len != 2'd0) begin
        phase_next = cpio_pkg::PH_NPAD;
      end else if (start_ph <= 3'd3 && data_length != 32'd0) begin
        phase_next = cpio_pkg::PH_DATA;
      end else if (start_ph <= 3'd4 && dpad_len != 2'd0) begin
        phase_next = cpio_pkg::PH_DPAD;
      end else if (trailer_match_next) begin
        phase_next = cpio_pkg::PH_END;
      end else begin
        phase_next       = cpio_pkg::PH_HEADER;
        entry_count_next = entry_count + EW'(1);
      end
    end
  end

  assign ended = trailer_match_next &&
                 ((phase >= cpio_pkg::PH_NPAD) || (phase == cpio_pkg::PH_NAME && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      phase         <= cpio_pkg::PH_HEADER;
      position      <= 32'd0;
      hex_acc       <= 32'd0;
      field_done    <= 1'b0;
      name_length   <= 32'd0;
      data_length   <= 32'd0;
      entry_count   <= '0;
      trailer_match <= 1'b1;
      bad_flag      <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
        s1_byte  <= archive_byte;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid     <= 1'b1;
        out_byte      <= s1_byte;
        out_region    <= phase;
        out_entry     <= entry_count_next;
        region_offset <= position;
        region_last   <= last;
        bad_hex       <= bad_flag_next;
        archive_end   <= ended;
        phase         <= phase_next;
        position      <= position_next;
        hex_acc       <= hex_acc_next;
        field_done    <= field_done_next;
        name_length   <= name_length_next;
        data_length   <= data_length_next;
        entry_count   <= entry_count_next;
        trailer_match <= trailer_match_next;
        bad_flag      <= bad_flag_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign region      = 3'(out_region);
  assign entry_index = 16'(out_entry);

  a_end_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == cpio_pkg::PH_END |=> phase == cpio_pkg::PH_END)
    else $error("walker left the past-end region");

  a_hdr_bound: assert property (@(posedge clk) disable iff (rst)
    phase == cpio_pkg::PH_HEADER |-> position < cpio_pkg::HDR_LEN)
    else $error("header position beyond header length");

  a_end_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_region == cpio_pkg::PH_END |-> archive_end && !region_last)
    else $error("past-end byte without end flag or with region_last");

  a_pad_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == cpio_pkg::PH_NPAD || phase == cpio_pkg::PH_DPAD) |-> position < 32'd3)
    else $error("pad position beyond three bytes");

endmodule

`default_nettype wire
